@@ rtl/shwd_pkg.sv @@
// ----------------------------------------------------------------------------
// shwd_pkg
// Shared types, constants and the take-step arithmetic of the subsequence
// scoring block.
// ----------------------------------------------------------------------------
package shwd_pkg;

	// Default sizes of the band.
	localparam int MAX_SEED_LEN   = 32;
	localparam int MAX_WINDOW_LEN = 64;

	// Fixed field widths.
	localparam int VAL_W   = 54;
	localparam int WGT_W   = 47;
	localparam int SCORE_W = 53;
	localparam int SEED_W  = 64;
	localparam int DATA_W  = 64;
	localparam int ADDR_W  = 5;

	typedef logic signed [VAL_W-1:0] val_t;

	// Register indexes on the configuration port.
	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_SEED_LEN = 2'd0;
	localparam reg_idx_t REG_WIN_LEN  = 2'd1;
	localparam reg_idx_t REG_THRESH   = 2'd2;

	// Request opcodes.
	localparam logic OP_TABLE  = 1'b0;
	localparam logic OP_LETTER = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROW,
		ST_SCORE,
		ST_RD,
		ST_USE,
		ST_OUT
	} state_t;

	// Controls broadcast to every cell of the chain.
	typedef struct packed {
		logic             tbl_we;
		logic [4:0]       tbl_pos;
		logic [1:0]       letter;
		logic [WGT_W-1:0] weight;
		logic             keep;
		logic             add;
		logic             calc;
		logic             upd;
	} cell_ctrl_t;

	// Controls for the backtrack unit.
	typedef struct packed {
		logic wr;
		logic start;
		logic rd;
		logic step;
	} trace_ctrl_t;

	// Keep or negate the running value, then add or subtract the weight.
	function automatic val_t take(input val_t v, input logic [WGT_W-1:0] w,
			input logic keep, input logic add);
		val_t a;
		val_t we;
		a  = keep ? v : -v;
		we = val_t'({{(VAL_W-WGT_W){1'b0}}, w});
		return add ? a + we : a - we;
	endfunction

endpackage

@@ rtl/shwd_if.sv @@
// ----------------------------------------------------------------------------
// shwd_if
// Valid/ready channels for the request and result streams.
// ----------------------------------------------------------------------------
interface shwd_in_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [4:0]  table_position;
	logic [1:0]  letter;
	logic [46:0] weight;
	logic        keep_sign;
	logic        add_sign;

	modport source(output valid, opcode, table_position, letter, weight, keep_sign,
		add_sign, input ready);
	modport sink(input valid, opcode, table_position, letter, weight, keep_sign,
		add_sign, output ready);
endinterface

interface shwd_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] seed;
	logic [52:0] score;
	logic        passes_threshold;
	logic        first_letter_used;

	modport source(output valid, seed, score, passes_threshold, first_letter_used,
		input ready);
	modport sink(input valid, seed, score, passes_threshold, first_letter_used,
		output ready);
endinterface

@@ rtl/shwd_cell.sv @@
// ----------------------------------------------------------------------------
// shwd_cell
// One column of the band DP: holds its table entries and the minimum and
// maximum of its column, fed by the left neighbor every row.
// ----------------------------------------------------------------------------
module shwd_cell #(
	parameter int IDX            = 0,
	parameter int MAX_WINDOW_LEN = shwd_pkg::MAX_WINDOW_LEN
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  shwd_pkg::cell_ctrl_t                ctl,
	input  logic [$clog2(MAX_WINDOW_LEN+1)-1:0] lc,
	input  shwd_pkg::val_t                      left_mn,
	input  shwd_pkg::val_t                      left_mx,
	output shwd_pkg::val_t                      mn,
	output shwd_pkg::val_t                      mx,
	output logic [3:0]                          flags
);

	logic [shwd_pkg::WGT_W-1:0] weight_q [4];
	logic [1:0]                 sign_q   [4];
	shwd_pkg::val_t             mn_q, mx_q;
	shwd_pkg::val_t             v1_s1, v2_s1;
	logic                       valid_s1;
	shwd_pkg::val_t             mn_n, mx_n;

	// Table entries for this seed position.
	always_ff @(posedge clk) begin
		if (ctl.tbl_we && int'(ctl.tbl_pos) == IDX) begin
			weight_q[ctl.letter] <= ctl.weight;
			sign_q[ctl.letter]   <= {ctl.add, ctl.keep};
		end
	end

	// First half of a row: both take candidates from the left column.
	always_ff @(posedge clk) begin
		if (ctl.calc) begin
			v1_s1    <= shwd_pkg::take(left_mn, weight_q[ctl.letter],
				sign_q[ctl.letter][0], sign_q[ctl.letter][1]);
			v2_s1    <= shwd_pkg::take(left_mx, weight_q[ctl.letter],
				sign_q[ctl.letter][0], sign_q[ctl.letter][1]);
			valid_s1 <= int'(lc) >= IDX + 1;
		end
	end

	// Second half: compare against the up cell, ties go to the take path.
	always_comb begin
		mn_n  = mn_q;
		mx_n  = mx_q;
		flags = 4'b1000;
		if (v1_s1 < v2_s1) begin
			if (!valid_s1 || v1_s1 <= mn_q) begin
				mn_n       = v1_s1;
				flags[1:0] = 2'b01;
			end
			if (!valid_s1 || v2_s1 >= mx_q) begin
				mx_n       = v2_s1;
				flags[3:2] = 2'b11;
			end
		end else begin
			if (!valid_s1 || v2_s1 <= mn_q) begin
				mn_n       = v2_s1;
				flags[1:0] = 2'b11;
			end
			if (!valid_s1 || v1_s1 >= mx_q) begin
				mx_n       = v1_s1;
				flags[3:2] = 2'b01;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mn_q <= '0;
			mx_q <= '0;
		end else if (ctl.upd) begin
			mn_q <= mn_n;
			mx_q <= mx_n;
		end
	end

	assign mn = mn_q;
	assign mx = mx_q;

endmodule

@@ rtl/shwd_trace.sv @@
// ----------------------------------------------------------------------------
// shwd_trace
// Choice flag memory, one row per letter, and the backtrack walk that
// collects the chosen letters.
// ----------------------------------------------------------------------------
module shwd_trace #(
	parameter int MAX_SEED_LEN   = shwd_pkg::MAX_SEED_LEN,
	parameter int MAX_WINDOW_LEN = shwd_pkg::MAX_WINDOW_LEN,
	localparam int RW     = $clog2(MAX_WINDOW_LEN + 1),
	localparam int KW     = $clog2(MAX_SEED_LEN + 1),
	localparam int CIW    = (MAX_SEED_LEN > 1) ? $clog2(MAX_SEED_LEN) : 1,
	localparam int WORD_W = 2 + 4 * MAX_SEED_LEN
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  shwd_pkg::trace_ctrl_t        ctrl,
	input  logic [RW-1:0]                wr_row,
	input  logic [WORD_W-1:0]            wr_word,
	input  logic [RW-1:0]                n,
	input  logic [KW-1:0]                k,
	input  logic                         use_max,
	output logic [shwd_pkg::SEED_W-1:0]  seed,
	output logic                         first,
	output logic                         done
);

	logic [WORD_W-1:0] mem [MAX_WINDOW_LEN+1];
	logic [WORD_W-1:0] rdata_q;
	logic [RW-1:0]     row_q;
	logic [KW-1:0]     col_q, picks_q, col_m1;
	logic              fm_q;
	logic [3:0]        fl_arr [MAX_SEED_LEN];
	logic [3:0]        fl;
	logic              sel, fm_n, cont;
	logic [1:0]        letter;

	// Flag memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (ctrl.wr) begin
			mem[wr_row] <= wr_word;
		end
		if (ctrl.rd) begin
			rdata_q <= mem[row_q];
		end
	end

	// Pick the flags of the current column out of the row word.
	always_comb begin
		for (int g = 0; g < MAX_SEED_LEN; g++) begin
			fl_arr[g] = rdata_q[4*g +: 4];
		end
		col_m1 = col_q - KW'(1);
		fl     = fl_arr[col_m1[CIW-1:0]];
		sel    = fm_q ? fl[2] : fl[0];
		fm_n   = fm_q ? fl[3] : fl[1];
		letter = rdata_q[WORD_W-1 -: 2];
		cont   = (picks_q < k) && (row_q != '0);
	end

	assign done  = ctrl.step && !cont;
	assign first = (row_q == '0) && (col_q == '0);

	// Walk state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q   <= '0;
			col_q   <= '0;
			picks_q <= '0;
			fm_q    <= 1'b0;
		end else if (ctrl.start) begin
			row_q   <= n;
			col_q   <= k;
			picks_q <= '0;
			fm_q    <= use_max;
		end else if (ctrl.step && cont) begin
			fm_q  <= fm_n;
			row_q <= row_q - RW'(1);
			if (sel) begin
				picks_q <= picks_q + KW'(1);
				col_q   <= col_q - KW'(1);
			end
		end
	end

	// Collected seed, first pick in the lowest bits.
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			seed <= '0;
		end else if (ctrl.step && cont && sel) begin
			seed <= seed | (shwd_pkg::SEED_W'(letter) << {picks_q, 1'b0});
		end
	end

endmodule

@@ rtl/subseq_hash_window_dp.sv @@
// ----------------------------------------------------------------------------
// subseq_hash_window_dp
// Band DP over a window of letters in a chain of column cells, followed by
// a backtrack that emits the best seed and its score.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake                 Carries
//  items    in   valid/ready               table write or window letter
//  results  out  valid/ready               seed, score, pass flag, first flag
//  apb      in   psel/penable/pwrite       register writes and reads
//
// A table write is taken while idle; a letter passes the cells' take stage
// and then their row update. The last letter of a window adds scoring and
// backtrack steps through the flag memory's read port, then the result is
// held until taken; no request is taken meanwhile.
// Reset clears the registers to their defaults and all control state.
module subseq_hash_window_dp #(
	parameter int MAX_SEED_LEN   = shwd_pkg::MAX_SEED_LEN,
	parameter int MAX_WINDOW_LEN = shwd_pkg::MAX_WINDOW_LEN
) (
	input  logic                         clk,
	input  logic                         arst_n,
	shwd_in_if.sink                      items,
	shwd_out_if.source                   results,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [shwd_pkg::ADDR_W-1:0]  paddr,
	input  logic [shwd_pkg::DATA_W-1:0]  pwdata,
	output logic [shwd_pkg::DATA_W-1:0]  prdata,
	output logic                         pready
);

	localparam int RW     = $clog2(MAX_WINDOW_LEN + 1);
	localparam int KW     = $clog2(MAX_SEED_LEN + 1);
	localparam int CIW    = (MAX_SEED_LEN > 1) ? $clog2(MAX_SEED_LEN) : 1;
	localparam int WORD_W = 2 + 4 * MAX_SEED_LEN;

	shwd_pkg::state_t              st_q, st_n;
	logic [5:0]                    seed_len_q;
	logic [6:0]                    win_len_q;
	logic [shwd_pkg::SCORE_W-1:0]  thresh_q;
	logic                          cfg_wr;
	shwd_pkg::reg_idx_t            cfg_idx;
	logic [RW-1:0]                 n, lc_q, lc_eff, row_s1, lc_next;
	logic [KW-1:0]                 k;
	logic [CIW-1:0]                kidx;
	logic [1:0]                    letter_s1;
	logic                          in_acc, last;
	shwd_pkg::cell_ctrl_t          cctl;
	shwd_pkg::trace_ctrl_t         tctl;
	shwd_pkg::val_t                mn_all [MAX_SEED_LEN];
	shwd_pkg::val_t                mx_all [MAX_SEED_LEN];
	logic [3:0]                    fl_all [MAX_SEED_LEN];
	logic [WORD_W-1:0]             row_word;
	shwd_pkg::val_t                sel_mn, sel_mx;
	logic [shwd_pkg::VAL_W-1:0]    abs_mn;
	logic                          use_max;
	logic [shwd_pkg::SCORE_W-1:0]  score_n, score_q;
	logic [shwd_pkg::SEED_W-1:0]   tr_seed;
	logic                          tr_first, tr_done;
	logic [shwd_pkg::SEED_W-1:0]   out_seed_q;
	logic [shwd_pkg::SCORE_W-1:0]  out_score_q;
	logic                          out_pass_q, out_first_q;

	// Configuration port.
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[4:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_len_q <= 6'd16;
			win_len_q  <= 7'd32;
			thresh_q   <= '0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				shwd_pkg::REG_SEED_LEN: seed_len_q <= pwdata[5:0];
				shwd_pkg::REG_WIN_LEN:  win_len_q  <= pwdata[6:0];
				shwd_pkg::REG_THRESH:   thresh_q   <= pwdata[shwd_pkg::SCORE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			shwd_pkg::REG_SEED_LEN: prdata = shwd_pkg::DATA_W'(seed_len_q);
			shwd_pkg::REG_WIN_LEN:  prdata = shwd_pkg::DATA_W'(win_len_q);
			shwd_pkg::REG_THRESH:   prdata = shwd_pkg::DATA_W'(thresh_q);
			default:                prdata = '0;
		endcase
	end

	// Effective window and seed lengths.
	always_comb begin
		int ni;
		int ki;
		ni = (win_len_q == '0) ? 1 : int'(win_len_q);
		if (ni > MAX_WINDOW_LEN) ni = MAX_WINDOW_LEN;
		ki = (seed_len_q == '0) ? 1 : int'(seed_len_q);
		if (ki > MAX_SEED_LEN) ki = MAX_SEED_LEN;
		if (ki > ni) ki = ni;
		n    = RW'(ni);
		k    = KW'(ki);
		kidx = CIW'(ki - 1);
	end

	// Row counter.
	assign in_acc  = items.valid && items.ready;
	assign lc_eff  = (lc_q >= n) ? '0 : lc_q;
	assign lc_next = row_s1 + RW'(1);
	assign last    = (lc_next == n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lc_q <= '0;
		end else if (cfg_wr && (cfg_idx == shwd_pkg::REG_SEED_LEN ||
				cfg_idx == shwd_pkg::REG_WIN_LEN)) begin
			lc_q <= '0;
		end else if (st_q == shwd_pkg::ST_ROW) begin
			lc_q <= last ? '0 : lc_next;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && items.opcode == shwd_pkg::OP_LETTER) begin
			row_s1    <= lc_eff;
			letter_s1 <= items.letter;
		end
	end

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= shwd_pkg::ST_IDLE;
		end else begin
			st_q <= st_n;
		end
	end

	// Next state.
	always_comb begin
		st_n = st_q;
		case (st_q)
			shwd_pkg::ST_IDLE: begin
				if (in_acc && items.opcode == shwd_pkg::OP_LETTER) st_n = shwd_pkg::ST_ROW;
			end
			shwd_pkg::ST_ROW: begin
				st_n = last ? shwd_pkg::ST_SCORE : shwd_pkg::ST_IDLE;
			end
			shwd_pkg::ST_SCORE: st_n = shwd_pkg::ST_RD;
			shwd_pkg::ST_RD:    st_n = shwd_pkg::ST_USE;
			shwd_pkg::ST_USE: begin
				st_n = tr_done ? shwd_pkg::ST_OUT : shwd_pkg::ST_RD;
			end
			shwd_pkg::ST_OUT: begin
				if (results.ready) st_n = shwd_pkg::ST_IDLE;
			end
			default: st_n = shwd_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		items.ready   = (st_q == shwd_pkg::ST_IDLE);
		results.valid = (st_q == shwd_pkg::ST_OUT);
		cctl.tbl_we   = in_acc && items.opcode == shwd_pkg::OP_TABLE;
		cctl.tbl_pos  = items.table_position;
		cctl.letter   = items.letter;
		cctl.weight   = items.weight;
		cctl.keep     = items.keep_sign;
		cctl.add      = items.add_sign;
		cctl.calc     = in_acc && items.opcode == shwd_pkg::OP_LETTER;
		cctl.upd      = (st_q == shwd_pkg::ST_ROW);
		tctl.wr       = (st_q == shwd_pkg::ST_ROW);
		tctl.start    = (st_q == shwd_pkg::ST_SCORE);
		tctl.rd       = (st_q == shwd_pkg::ST_RD);
		tctl.step     = (st_q == shwd_pkg::ST_USE);
	end

	// Chain of column cells; column zero is the constant zero.
	for (genvar g = 0; g < MAX_SEED_LEN; g++) begin : g_cell
		shwd_pkg::val_t lmn, lmx;
		if (g == 0) begin : g_first
			assign lmn = '0;
			assign lmx = '0;
		end else begin : g_rest
			assign lmn = mn_all[g-1];
			assign lmx = mx_all[g-1];
		end
		shwd_cell #(
			.IDX           (g),
			.MAX_WINDOW_LEN(MAX_WINDOW_LEN)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (cctl),
			.lc     (lc_eff),
			.left_mn(lmn),
			.left_mx(lmx),
			.mn     (mn_all[g]),
			.mx     (mx_all[g]),
			.flags  (fl_all[g])
		);
		assign row_word[4*g +: 4] = fl_all[g];
	end
	assign row_word[WORD_W-1 -: 2] = letter_s1;

	// Score of cell (n,k).
	always_comb begin
		sel_mn  = mn_all[kidx];
		sel_mx  = mx_all[kidx];
		abs_mn  = sel_mn[shwd_pkg::VAL_W-1] ? $unsigned(-sel_mn) : $unsigned(sel_mn);
		use_max = !sel_mx[shwd_pkg::VAL_W-1] && (sel_mx != '0) &&
			($unsigned(sel_mx) > abs_mn);
		score_n = use_max ? sel_mx[shwd_pkg::SCORE_W-1:0] : abs_mn[shwd_pkg::SCORE_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (tctl.start) begin
			score_q <= score_n;
		end
	end

	shwd_trace #(
		.MAX_SEED_LEN  (MAX_SEED_LEN),
		.MAX_WINDOW_LEN(MAX_WINDOW_LEN)
	) u_trace (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (tctl),
		.wr_row (lc_next),
		.wr_word(row_word),
		.n      (n),
		.k      (k),
		.use_max(use_max),
		.seed   (tr_seed),
		.first  (tr_first),
		.done   (tr_done)
	);

	// Result register.
	always_ff @(posedge clk) begin
		if (tr_done) begin
			out_seed_q  <= tr_seed;
			out_score_q <= score_q;
			out_pass_q  <= (score_q >= thresh_q);
			out_first_q <= tr_first;
		end
	end

	assign results.seed              = out_seed_q;
	assign results.score             = out_score_q;
	assign results.passes_threshold  = out_pass_q;
	assign results.first_letter_used = out_first_q;

endmodule

@@ rtl/shwd_checker.sv @@
// ----------------------------------------------------------------------------
// shwd_checker
// Port-level checks on request and result traffic of the top level.
// ----------------------------------------------------------------------------
module shwd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_opcode,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] out_seed
);

	// No request is taken while a result waits.
	a_busy_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("request taken while a result is pending");

	// A table write never produces a result.
	a_table_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_opcode == shwd_pkg::OP_TABLE) |=> !out_valid)
		else $error("result after a table write");

	// One result per window: a taken result is not shown again.
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready) |=> !out_valid)
		else $error("result repeated");

	// A stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_seed)))
		else $error("stalled result changed");

endmodule

bind subseq_hash_window_dp shwd_checker u_shwd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (items.valid),
	.in_ready (items.ready),
	.in_opcode(items.opcode),
	.out_valid(results.valid),
	.out_ready(results.ready),
	.out_seed (results.seed)
);

@@ verif/tb_subseq_hash_window_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_subseq_hash_window_dp
// Self-checking bench for the subsequence scoring block. Table writes and
// window letters are driven through a bursty valid/ready source. An
// in-bench band DP with backtrack predicts each result, and every result
// is checked field by field. Several length and threshold settings are
// programmed over the register port while the block is idle.
// ----------------------------------------------------------------------------
module tb_subseq_hash_window_dp;

	localparam int  NCOL       = shwd_pkg::MAX_SEED_LEN + 1;
	localparam int  IDLE_LIMIT = 20000;
	localparam longint SCORE_MASK = (64'd1 << shwd_pkg::SCORE_W) - 1;

	typedef struct {
		logic        op;
		logic [4:0]  pos;
		logic [1:0]  letter;
		logic [46:0] weight;
		logic        keep;
		logic        add;
	} request_t;

	typedef struct {
		logic [63:0] seed;
		logic [52:0] score;
		logic        pass;
		logic        first;
	} seed_result_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [shwd_pkg::ADDR_W-1:0] paddr;
	logic [shwd_pkg::DATA_W-1:0] pwdata;
	logic [shwd_pkg::DATA_W-1:0] prdata;
	logic pready;

	shwd_in_if  in_ch();
	shwd_out_if out_ch();

	subseq_hash_window_dp u_top (
		.clk(clk), .arst_n(arst_n), .items(in_ch), .results(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Pending requests and expected results.
	request_t     pending_reqs[$];
	seed_result_t expected_seeds[$];
	int           errors = 0;

	// Shadow of the block's state.
	longint      weights[128];
	logic [1:0]  signs[128];
	logic [1:0]  win_letters[shwd_pkg::MAX_WINDOW_LEN];
	longint      row_min[NCOL];
	longint      row_max[NCOL];
	logic [3:0]  choice[(shwd_pkg::MAX_WINDOW_LEN+1)*NCOL];
	int          letters_seen = 0;
	logic [5:0]  cfg_k = 6'd16;
	logic [6:0]  cfg_n = 7'd32;
	logic [52:0] cfg_thresh = '0;

	// Pacing controls set by the stimulus process.
	int  gap_max = 4;
	int  stall_pct = 30;
	bit  hold_request = 0;
	bit  in_took = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic int win_len();
		int n;
		n = cfg_n;
		if (n == 0) n = 1;
		if (n > shwd_pkg::MAX_WINDOW_LEN) n = shwd_pkg::MAX_WINDOW_LEN;
		return n;
	endfunction

	function automatic int seed_len();
		int k;
		k = cfg_k;
		if (k == 0) k = 1;
		if (k > shwd_pkg::MAX_SEED_LEN) k = shwd_pkg::MAX_SEED_LEN;
		if (k > win_len()) k = win_len();
		return k;
	endfunction

	function automatic longint take_step(longint v, int pos, logic [1:0] ltr);
		int idx;
		idx = pos * 4 + ltr;
		if (!signs[idx][0]) v = -v;
		return signs[idx][1] ? v + weights[idx] : v - weights[idx];
	endfunction

	// Advance the band DP by one letter and, at the end of a window,
	// backtrack to form the expected result.
	task automatic predict_request(request_t r);
		int n, k, i, j, minj, maxj, row, col, picks;
		bit up_ok, sel, fm;
		longint mn, mx, v1, v2, score;
		logic [3:0] fl;
		logic [63:0] seed;
		seed_result_t res;
		if (r.op == shwd_pkg::OP_TABLE) begin
			weights[r.pos*4 + r.letter] = r.weight;
			signs[r.pos*4 + r.letter] = {r.add, r.keep};
			return;
		end
		n = win_len();
		k = seed_len();
		if (letters_seen >= n) letters_seen = 0;
		if (letters_seen == 0) begin
			foreach (row_min[c]) begin
				row_min[c] = 0;
				row_max[c] = 0;
			end
			foreach (choice[c]) choice[c] = 4'h0;
		end
		win_letters[letters_seen] = r.letter;
		letters_seen++;
		i = letters_seen;
		if (i == 1) begin
			v1 = take_step(0, 0, r.letter);
			row_min[1] = v1;
			row_max[1] = v1;
			choice[NCOL + 1] = 4'h5;
		end else begin
			minj = (i - (n - k) > 1) ? i - (n - k) : 1;
			maxj = (i < k) ? i : k;
			for (j = maxj; j >= minj; j--) begin
				up_ok = (i - 1 >= j);
				mn = 0;
				mx = 0;
				fl = 4'h0;
				if (up_ok) begin
					mn = row_min[j];
					mx = row_max[j];
					fl = 4'h8;
				end
				v1 = take_step(row_min[j-1], j - 1, r.letter);
				v2 = take_step(row_max[j-1], j - 1, r.letter);
				if (v1 < v2) begin
					if (!up_ok || v1 <= mn) begin mn = v1; fl = (fl & 4'hC) | 4'h1; end
					if (!up_ok || v2 >= mx) begin mx = v2; fl = (fl & 4'h3) | 4'hC; end
				end else begin
					if (!up_ok || v2 <= mn) begin mn = v2; fl = (fl & 4'hC) | 4'h3; end
					if (!up_ok || v1 >= mx) begin mx = v1; fl = (fl & 4'h3) | 4'h4; end
				end
				row_min[j] = mn;
				row_max[j] = mx;
				choice[i*NCOL + j] = fl;
			end
		end
		if (letters_seen < n) return;
		letters_seen = 0;

		// Pick the larger magnitude, then walk the flags back to row zero.
		mn = row_min[k];
		mx = row_max[k];
		fl = choice[n*NCOL + k];
		score = (mn < 0) ? -mn : mn;
		if (mx > 0 && mx > score) begin
			score = mx;
			sel = fl[2];
			fm = fl[3];
		end else begin
			sel = fl[0];
			fm = fl[1];
		end
		row = n;
		col = k;
		picks = 0;
		seed = '0;
		while (picks < k && row > 0) begin
			if (sel) begin
				seed |= 64'(win_letters[row-1]) << (2 * picks);
				picks++;
				col--;
			end
			row--;
			fl = choice[row*NCOL + col];
			if (fm) begin
				sel = fl[2];
				fm = fl[3];
			end else begin
				sel = fl[0];
				fm = fl[1];
			end
		end
		score &= SCORE_MASK;
		res.seed = seed;
		res.score = score[52:0];
		res.pass = (score[52:0] >= cfg_thresh);
		res.first = (row == 0 && col == 0);
		expected_seeds = {expected_seeds, res};
	endtask

	// Register write over the APB port, mirrored into the shadow settings.
	task automatic write_reg(shwd_pkg::reg_idx_t idx, logic [63:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= shwd_pkg::ADDR_W'(idx * 8);
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			shwd_pkg::REG_SEED_LEN: begin cfg_k = value[5:0]; letters_seen = 0; end
			shwd_pkg::REG_WIN_LEN: begin cfg_n = value[6:0]; letters_seen = 0; end
			default: cfg_thresh = value[52:0];
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Wait until every request is taken and every result has come back.
	task automatic wait_drained();
		wait (pending_reqs.size() == 0);
		@(negedge clk);
		wait (expected_seeds.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [46:0] rand_weight();
		case ($urandom_range(3))
			0: return '0;
			1: return '1;
			2: return 47'($urandom_range(1 << 20));
			default: return {15'($urandom), $urandom};
		endcase
	endfunction

	task automatic push_table(int pos, int ltr, logic [46:0] w, bit keep, bit add);
		request_t r;
		r.op = shwd_pkg::OP_TABLE;
		r.pos = 5'(pos);
		r.letter = 2'(ltr);
		r.weight = w;
		r.keep = keep;
		r.add = add;
		pending_reqs = {pending_reqs, r};
	endtask

	task automatic push_letter(int ltr);
		request_t r;
		r.op = shwd_pkg::OP_LETTER;
		r.pos = 5'($urandom);
		r.letter = 2'(ltr);
		r.weight = {15'($urandom), $urandom};
		r.keep = 1'($urandom_range(1));
		r.add = 1'($urandom_range(1));
		pending_reqs = {pending_reqs, r};
	endtask

	// Random mix: mostly letters, some table rewrites.
	task automatic push_random(int count);
		for (int c = 0; c < count; c++) begin
			if ($urandom_range(4) == 0)
				push_table($urandom_range(31), $urandom_range(3), rand_weight(),
					1'($urandom_range(1)), 1'($urandom_range(1)));
			else
				push_letter($urandom_range(3));
		end
	endtask

	// Driver: requests change at the falling edge.
	int burst_left = 0;
	int gap_left = 0;
	always @(negedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else if (in_ch.valid && !in_took) begin
			in_ch.valid <= 1'b1;
		end else if (gap_left > 0) begin
			gap_left--;
			in_ch.valid <= 1'b0;
		end else if (pending_reqs.size() > 0) begin
			in_ch.valid <= 1'b1;
			in_ch.opcode <= pending_reqs[0].op;
			in_ch.table_position <= pending_reqs[0].pos;
			in_ch.letter <= pending_reqs[0].letter;
			in_ch.weight <= pending_reqs[0].weight;
			in_ch.keep_sign <= pending_reqs[0].keep;
			in_ch.add_sign <= pending_reqs[0].add;
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				burst_left = $urandom_range(20);
				gap_left = (gap_max == 0) ? 0 : $urandom_range(gap_max);
			end
		end else begin
			in_ch.valid <= 1'b0;
		end
	end

	// Receiver stall pattern, with a long hold-off on request.
	int hold_left = 0;
	always @(negedge clk) begin
		if (hold_request && hold_left == 0) begin
			hold_left = 600;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Acceptance of requests, results checking and the watchdog.
	int idle_cycles = 0;
	seed_result_t exp_res;
	always @(posedge clk) begin
		in_took = 0;
		idle_cycles++;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			in_took = 1;
			idle_cycles = 0;
			predict_request(pending_reqs.pop_front());
		end
		if (psel && penable) idle_cycles = 0;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			idle_cycles = 0;
			if (expected_seeds.size() == 0) begin
				errors++;
				$display("%0t: unexpected result seed=%h score=%h", $time,
					out_ch.seed, out_ch.score);
			end else begin
				exp_res = expected_seeds.pop_front();
				if (out_ch.seed !== exp_res.seed) begin
					errors++;
					$display("%0t: seed expected %h actual %h", $time, exp_res.seed,
						out_ch.seed);
				end
				if (out_ch.score !== exp_res.score) begin
					errors++;
					$display("%0t: score expected %h actual %h", $time, exp_res.score,
						out_ch.score);
				end
				if (out_ch.passes_threshold !== exp_res.pass) begin
					errors++;
					$display("%0t: passes_threshold expected %b actual %b", $time,
						exp_res.pass, out_ch.passes_threshold);
				end
				if (out_ch.first_letter_used !== exp_res.first) begin
					errors++;
					$display("%0t: first_letter_used expected %b actual %b", $time,
						exp_res.first, out_ch.first_letter_used);
				end
			end
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Settings per phase: seed length, window length, threshold, pacing.
	logic [5:0]  ph_k[12]   = '{1, 32, 0, 63, 5, 4, 2, 8, 1, 12, 3, 32};
	logic [6:0]  ph_n[12]   = '{1, 64, 0, 127, 3, 8, 5, 12, 10, 12, 20, 40};
	int          ph_gap[12] = '{0, 3, 6, 0, 2, 8, 1, 4, 0, 5, 3, 2};
	int          ph_stall[12] = '{0, 20, 50, 0, 70, 10, 30, 0, 40, 20, 60, 10};

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Fill every table cell so no unwritten cell is ever read, with
		// both weight extremes and all sign combinations.
		for (int p = 0; p < 32; p++)
			for (int l = 0; l < 4; l++)
				push_table(p, l, (p % 3 == 0) ? '1 : ((p % 3 == 1) ? '0 : rand_weight()),
					l[0], l[1]);
		// Default settings: one full window plus a partial one.
		for (int l = 0; l < 40; l++) push_letter(l % 4);
		wait_drained();

		for (int ph = 0; ph < 12; ph++) begin
			write_reg(shwd_pkg::REG_SEED_LEN, 64'(ph_k[ph]));
			write_reg(shwd_pkg::REG_WIN_LEN, 64'(ph_n[ph]));
			case (ph % 3)
				0: write_reg(shwd_pkg::REG_THRESH, 64'd0);
				1: write_reg(shwd_pkg::REG_THRESH, {11'h7FF, 53'h1F_FFFF_FFFF_FFFF});
				default: write_reg(shwd_pkg::REG_THRESH,
					{$urandom_range(1 << 20), $urandom});
			endcase
			gap_max = ph_gap[ph];
			stall_pct = ph_stall[ph];
			if (ph == 0) begin
				// Single-letter windows: every letter value.
				for (int l = 0; l < 4; l++) push_letter(l);
			end
			if (ph == 2) hold_request = 1;
			push_random((ph == 1 || ph == 3) ? 140 : 150);
			if (ph == 5) begin
				// Sender pauses until every result is back, then resumes.
				wait_drained();
				push_random(40);
			end
			wait_drained();
		end

		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
